[hw/rtl/rpf_pkg.sv]
// Package for the run-length page framebuffer: geometry constants, command
// and state codes, and the pixel-to-byte address helpers.
// No dependencies.
package rpf_pkg;

    localparam int WIDTH        = 128;
    localparam int HEIGHT       = 64;
    localparam int PAGES        = (HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = WIDTH * PAGES;
    localparam int TOTAL_PIXELS = WIDTH * HEIGHT;

    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int X_W     = $clog2(WIDTH);
    localparam int Y_W     = $clog2(HEIGHT + 1);
    localparam int POS_W   = $clog2(TOTAL_PIXELS + 1);
    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 8;
    localparam int CMD_W   = 2;
    localparam int PX_W    = 7;
    localparam int PY_W    = 6;
    localparam int RADDR_W = 10;
    localparam int NPOS_W  = 14;

    typedef enum logic [CMD_W-1:0] {
        CMD_RUN   = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_WB,
        ST_RD
    } t_state;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [X_W-1:0] x,
                                                   input logic [Y_W-1:0] y);
        return ADDR_W'(int'(x) + int'(y >> 3) * WIDTH);
    endfunction

    function automatic logic [BYTE_W-1:0] bit_mask(input logic [Y_W-1:0] y);
        return BYTE_W'(1) << y[2:0];
    endfunction

endpackage

[hw/rtl/rpf_store.sv]
// Framebuffer byte store: one write port, one read port with registered data.
// No dependencies.
module rpf_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rle_page_framebuffer.sv]
// Run-length page framebuffer: command sequencer, raster tracking and
// read-modify-write of the byte store.
// Depends on rpf_pkg and rpf_store.
//
// A command is taken when start is high and busy is low; its single result is
// presented for one cycle with o_done high and cannot be held off, so the
// receiver must capture it then. After reset the block runs a clearing pass
// over all STORE_BYTES bytes (1024) with busy high. A run byte advances one
// pixel per cycle through a pipelined read-modify-write of the store; a
// frame's first byte adds a clearing pass in front.
module rle_page_framebuffer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rpf_pkg::CMD_W-1:0]   i_cmd,
    input  logic                        i_first_of_frame,
    input  logic [rpf_pkg::RUN_W-1:0]   i_run_length,
    input  logic [rpf_pkg::PX_W-1:0]    i_pixel_x,
    input  logic [rpf_pkg::PY_W-1:0]    i_pixel_y,
    input  logic                        i_pixel_value,
    input  logic [rpf_pkg::RADDR_W-1:0] i_read_address,
    output logic                        o_done,
    output logic [rpf_pkg::BYTE_W-1:0]  o_read_data,
    output logic [rpf_pkg::NPOS_W-1:0]  o_next_position,
    output logic                        o_current_color,
    output logic                        o_frame_full,
    output logic                        o_pixels_dropped
);

    rpf_pkg::t_state                r_state,    n_state;
    logic [rpf_pkg::X_W-1:0]        r_x,        n_x;
    logic [rpf_pkg::Y_W-1:0]        r_y,        n_y;
    logic [rpf_pkg::POS_W-1:0]      r_pos,      n_pos;
    logic                           r_color,    n_color;
    logic [rpf_pkg::RUN_W-1:0]      r_rem,      n_rem;
    logic [rpf_pkg::ADDR_W-1:0]     r_clr_addr, n_clr_addr;
    logic                           r_clr_run,  n_clr_run;
    logic                           r_wr_pend,  n_wr_pend;
    logic [rpf_pkg::ADDR_W-1:0]     r_wr_addr,  n_wr_addr;
    logic [rpf_pkg::BYTE_W-1:0]     r_wr_mask,  n_wr_mask;
    logic                           r_wr_set,   n_wr_set;
    logic                           r_rd_ok,    n_rd_ok;
    logic [rpf_pkg::BYTE_W-1:0]     r_read_data, n_read_data;
    logic                           r_dropped,  n_dropped;
    logic                           r_done,     n_done;

    logic                           clr_we;
    logic [rpf_pkg::ADDR_W-1:0]     mem_raddr;
    logic [rpf_pkg::BYTE_W-1:0]     mem_rdata;
    logic                           mem_we;
    logic [rpf_pkg::ADDR_W-1:0]     mem_waddr;
    logic [rpf_pkg::BYTE_W-1:0]     mem_wdata;

    logic                           pix_ok;
    logic                           rd_ok;
    logic [rpf_pkg::X_W-1:0]        in_x;
    logic [rpf_pkg::Y_W-1:0]        in_y;
    logic [rpf_pkg::POS_W-1:0]      pos_eff;
    logic [rpf_pkg::POS_W-1:0]      room;
    logic                           run_drop;
    logic [rpf_pkg::RUN_W-1:0]      run_n;

    rpf_store #(
        .DEPTH  (rpf_pkg::STORE_BYTES),
        .DATA_W (rpf_pkg::BYTE_W),
        .ADDR_W (rpf_pkg::ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign mem_we    = clr_we | r_wr_pend;
    assign mem_waddr = clr_we ? r_clr_addr : r_wr_addr;
    assign mem_wdata = clr_we    ? '0 :
                       r_wr_set  ? (mem_rdata | r_wr_mask) :
                                   (mem_rdata & ~r_wr_mask);

    assign pix_ok   = (int'(i_pixel_x) < rpf_pkg::WIDTH) && (int'(i_pixel_y) < rpf_pkg::HEIGHT);
    assign rd_ok    = int'(i_read_address) < rpf_pkg::STORE_BYTES;
    assign in_x     = rpf_pkg::X_W'(i_pixel_x);
    assign in_y     = rpf_pkg::Y_W'(i_pixel_y);
    assign pos_eff  = i_first_of_frame ? '0 : r_pos;
    assign room     = rpf_pkg::POS_W'(rpf_pkg::TOTAL_PIXELS) - pos_eff;
    assign run_drop = int'(i_run_length) > int'(room);
    assign run_n    = run_drop ? rpf_pkg::RUN_W'(room) : i_run_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rpf_pkg::ST_CLEAR;
            r_x        <= '0;
            r_y        <= '0;
            r_pos      <= '0;
            r_color    <= 1'b0;
            r_rem      <= '0;
            r_clr_addr <= '0;
            r_clr_run  <= 1'b0;
            r_wr_pend  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_x        <= n_x;
            r_y        <= n_y;
            r_pos      <= n_pos;
            r_color    <= n_color;
            r_rem      <= n_rem;
            r_clr_addr <= n_clr_addr;
            r_clr_run  <= n_clr_run;
            r_wr_pend  <= n_wr_pend;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr   <= n_wr_addr;
        r_wr_mask   <= n_wr_mask;
        r_wr_set    <= n_wr_set;
        r_rd_ok     <= n_rd_ok;
        r_read_data <= n_read_data;
        r_dropped   <= n_dropped;
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_pos       = r_pos;
        n_color     = r_color;
        n_rem       = r_rem;
        n_clr_addr  = r_clr_addr;
        n_clr_run   = r_clr_run;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_wr_mask   = r_wr_mask;
        n_wr_set    = r_wr_set;
        n_rd_ok     = r_rd_ok;
        n_read_data = r_read_data;
        n_dropped   = r_dropped;
        n_done      = 1'b0;
        clr_we      = 1'b0;
        mem_raddr   = rpf_pkg::pix_addr(r_x, r_y);

        unique case (r_state)
            rpf_pkg::ST_CLEAR: begin
                clr_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == rpf_pkg::ADDR_W'(rpf_pkg::STORE_BYTES - 1)) begin
                    n_state = r_clr_run ? rpf_pkg::ST_RUN : rpf_pkg::ST_IDLE;
                end
            end
            rpf_pkg::ST_IDLE: begin
                if (rpf_pkg::t_cmd'(i_cmd) == rpf_pkg::CMD_PIXEL) begin
                    mem_raddr = rpf_pkg::pix_addr(in_x, in_y);
                end else begin
                    mem_raddr = rpf_pkg::ADDR_W'(i_read_address);
                end
                if (start) begin
                    n_dropped = 1'b0;
                    unique case (rpf_pkg::t_cmd'(i_cmd))
                        rpf_pkg::CMD_RUN: begin
                            n_dropped = run_drop;
                            n_rem     = run_n;
                            n_pos     = pos_eff + rpf_pkg::POS_W'(run_n);
                            if (i_first_of_frame) begin
                                n_color    = 1'b0;
                                n_x        = '0;
                                n_y        = '0;
                                n_clr_addr = '0;
                                n_clr_run  = 1'b1;
                                n_state    = rpf_pkg::ST_CLEAR;
                            end else begin
                                n_color = ~r_color;
                                n_state = rpf_pkg::ST_RUN;
                            end
                        end
                        rpf_pkg::CMD_PIXEL: begin
                            n_wr_pend = pix_ok;
                            n_wr_addr = rpf_pkg::pix_addr(in_x, in_y);
                            n_wr_mask = rpf_pkg::bit_mask(in_y);
                            n_wr_set  = i_pixel_value;
                            n_state   = rpf_pkg::ST_WB;
                        end
                        rpf_pkg::CMD_READ: begin
                            n_rd_ok = rd_ok;
                            n_state = rpf_pkg::ST_RD;
                        end
                        rpf_pkg::CMD_NOP: begin
                            n_read_data = '0;
                            n_done      = 1'b1;
                        end
                        default: begin
                            n_state = rpf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rpf_pkg::ST_RUN: begin
                if (r_rem != '0) begin
                    n_rem = r_rem - 1'b1;
                    if (r_color) begin
                        n_wr_pend = 1'b1;
                        n_wr_addr = rpf_pkg::pix_addr(r_x, r_y);
                        n_wr_mask = rpf_pkg::bit_mask(r_y);
                        n_wr_set  = 1'b1;
                    end
                    if (r_x == rpf_pkg::X_W'(rpf_pkg::WIDTH - 1)) begin
                        n_x = '0;
                        n_y = r_y + 1'b1;
                    end else begin
                        n_x = r_x + 1'b1;
                    end
                end else begin
                    n_read_data = '0;
                    n_done      = 1'b1;
                    n_state     = rpf_pkg::ST_IDLE;
                end
            end
            rpf_pkg::ST_WB: begin
                n_read_data = '0;
                n_done      = 1'b1;
                n_state     = rpf_pkg::ST_IDLE;
            end
            rpf_pkg::ST_RD: begin
                n_read_data = r_rd_ok ? mem_rdata : '0;
                n_done      = 1'b1;
                n_state     = rpf_pkg::ST_IDLE;
            end
            default: begin
                n_state = rpf_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != rpf_pkg::ST_IDLE);
    assign o_done           = r_done;
    assign o_read_data      = r_read_data;
    assign o_next_position  = rpf_pkg::NPOS_W'(r_pos);
    assign o_current_color  = r_color;
    assign o_frame_full     = (r_pos == rpf_pkg::POS_W'(rpf_pkg::TOTAL_PIXELS));
    assign o_pixels_dropped = r_dropped;

endmodule

[tb/tb.sv]
// Self-checking testbench for rle_page_framebuffer: a directed table, then random frames.
// Typed rows are scored on a literal, the rest on an in-bench store/raster/colour model.
// Depends on rpf_pkg and the framebuffer RTL.
`timescale 1ns / 100ps

module tb;

    localparam int ITEMS          = 1150;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int DIRECTED_ROWS  = 25;

    typedef struct packed {
        rpf_pkg::t_cmd                      cmd;
        logic                               first;
        logic [rpf_pkg::RUN_W-1:0]          run;
        logic [rpf_pkg::PX_W-1:0]           px;
        logic [rpf_pkg::PY_W-1:0]           py;
        logic                               pv;
        logic [rpf_pkg::RADDR_W-1:0]        raddr;
    } t_fb_request;

    typedef struct packed {
        logic [rpf_pkg::BYTE_W-1:0]         rdata;
        logic [rpf_pkg::NPOS_W-1:0]         next_pos;
        logic                               colour;
        logic                               full;
        logic                               dropped;
    } t_fb_response;

    typedef struct packed {
        t_fb_request                        req;
        logic [5:0]                         reps;
        logic                               typed;
        t_fb_response                       rsp;
    } t_fb_row;

    localparam t_fb_response NO_RSP = '0;

    // request: cmd, first, run, x, y, value, address / repeats / typed / response
    localparam t_fb_row FB_ROWS [DIRECTED_ROWS] = '{
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b1, NO_RSP},
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd1023}, 6'd1, 1'b1, NO_RSP},
        '{'{rpf_pkg::CMD_NOP, 1'b1, 8'hFF, 7'h7F, 6'h3F, 1'b1, 10'h3FF}, 6'd1, 1'b1, NO_RSP},
        '{'{rpf_pkg::CMD_PIXEL, 1'b0, 8'd0, 7'd127, 6'd63, 1'b1, 10'd0}, 6'd1, 1'b1, NO_RSP},
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd1023}, 6'd1, 1'b1,
          '{8'h80, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{'{rpf_pkg::CMD_PIXEL, 1'b0, 8'd0, 7'd0, 6'd0, 1'b1, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_READ, 1'b1, 8'hFF, 7'h7F, 6'h3F, 1'b1, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_PIXEL, 1'b0, 8'd0, 7'd127, 6'd63, 1'b0, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd1023}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_RUN, 1'b1, 8'd255, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b1,
          '{8'h00, 14'd255, 1'b0, 1'b0, 1'b0}},
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b1,
          '{8'h00, 14'd255, 1'b0, 1'b0, 1'b0}},
        '{'{rpf_pkg::CMD_RUN, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b1,
          '{8'h00, 14'd255, 1'b1, 1'b0, 1'b0}},
        '{'{rpf_pkg::CMD_RUN, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_RUN, 1'b0, 8'd200, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd2}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_PIXEL, 1'b0, 8'd0, 7'd2, 6'd2, 1'b0, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd2}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_RUN, 1'b0, 8'd255, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd31, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_RUN, 1'b0, 8'd255, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_RUN, 1'b0, 8'd10, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_RUN, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd1020}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_PIXEL, 1'b0, 8'd0, 7'd5, 6'd40, 1'b1, 10'd0}, 6'd1, 1'b0, NO_RSP},
        '{'{rpf_pkg::CMD_RUN, 1'b1, 8'd0, 7'd0, 6'd0, 1'b0, 10'd0}, 6'd1, 1'b1, NO_RSP},
        '{'{rpf_pkg::CMD_READ, 1'b0, 8'd0, 7'd0, 6'd0, 1'b0, 10'd1023}, 6'd1, 1'b1, NO_RSP}
    };

    logic                                i_clk            = 1'b0;
    logic                                i_rst_n          = 1'b0;
    logic                                start            = 1'b0;
    logic                                busy;
    logic [rpf_pkg::CMD_W-1:0]           i_cmd            = '0;
    logic                                i_first_of_frame = 1'b0;
    logic [rpf_pkg::RUN_W-1:0]           i_run_length     = '0;
    logic [rpf_pkg::PX_W-1:0]            i_pixel_x        = '0;
    logic [rpf_pkg::PY_W-1:0]            i_pixel_y        = '0;
    logic                                i_pixel_value    = 1'b0;
    logic [rpf_pkg::RADDR_W-1:0]         i_read_address   = '0;
    logic                                o_done;
    logic [rpf_pkg::BYTE_W-1:0]          o_read_data;
    logic [rpf_pkg::NPOS_W-1:0]          o_next_position;
    logic                                o_current_color;
    logic                                o_frame_full;
    logic                                o_pixels_dropped;

    logic [rpf_pkg::BYTE_W-1:0]          fb_bytes [rpf_pkg::STORE_BYTES];
    int unsigned                         fb_pos;
    logic                                fb_colour;
    t_fb_response                        fb_expected [$];
    int unsigned                         fb_sent;
    int unsigned                         idle_count;
    bit                                  fb_failed;
    bit                                  no_idle;

    rle_page_framebuffer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_first_of_frame (i_first_of_frame),
        .i_run_length     (i_run_length),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_pixel_value    (i_pixel_value),
        .i_read_address   (i_read_address),
        .o_done           (o_done),
        .o_read_data      (o_read_data),
        .o_next_position  (o_next_position),
        .o_current_color  (o_current_color),
        .o_frame_full     (o_frame_full),
        .o_pixels_dropped (o_pixels_dropped)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_fb_response fb_predict(input t_fb_request req);
        t_fb_response rsp;
        int unsigned  room;
        int unsigned  count;
        int unsigned  p;
        int unsigned  addr;
        rsp = '0;
        case (req.cmd)
            rpf_pkg::CMD_RUN: begin
                if (req.first) begin
                    foreach (fb_bytes[a]) fb_bytes[a] = '0;
                    fb_pos    = 0;
                    fb_colour = 1'b0;
                end else begin
                    fb_colour = ~fb_colour;
                end
                room  = rpf_pkg::TOTAL_PIXELS - fb_pos;
                count = req.run;
                if (count > room) begin
                    count       = room;
                    rsp.dropped = 1'b1;
                end
                if (fb_colour) begin
                    for (int i = 0; i < count; i++) begin
                        p    = fb_pos + i;
                        addr = p % rpf_pkg::WIDTH + (p / rpf_pkg::WIDTH / 8) * rpf_pkg::WIDTH;
                        fb_bytes[addr] |= rpf_pkg::BYTE_W'(1) << ((p / rpf_pkg::WIDTH) % 8);
                    end
                end
                fb_pos += count;
            end
            rpf_pkg::CMD_PIXEL: begin
                addr = int'(req.px) + int'(req.py / 8) * rpf_pkg::WIDTH;
                if (req.pv) fb_bytes[addr] |= rpf_pkg::BYTE_W'(1) << req.py[2:0];
                else        fb_bytes[addr] &= ~(rpf_pkg::BYTE_W'(1) << req.py[2:0]);
            end
            rpf_pkg::CMD_READ: begin
                rsp.rdata = fb_bytes[req.raddr];
            end
            default: ;
        endcase
        rsp.next_pos = rpf_pkg::NPOS_W'(fb_pos);
        rsp.colour   = fb_colour;
        rsp.full     = (fb_pos >= rpf_pkg::TOTAL_PIXELS);
        return rsp;
    endfunction

    function automatic t_fb_request fb_scramble();
        t_fb_request req;
        req.cmd   = rpf_pkg::t_cmd'($urandom_range(0, 3));
        req.first = 1'($urandom_range(0, 1));
        req.run   = rpf_pkg::RUN_W'($urandom_range(0, 255));
        req.px    = rpf_pkg::PX_W'($urandom_range(0, 127));
        req.py    = rpf_pkg::PY_W'($urandom_range(0, 63));
        req.pv    = 1'($urandom_range(0, 1));
        req.raddr = rpf_pkg::RADDR_W'($urandom_range(0, 1023));
        return req;
    endfunction

    task automatic fb_issue(input t_fb_request req, input logic typed, input t_fb_response lit);
        int unsigned  gap;
        t_fb_response predicted;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_cmd            <= req.cmd;
        i_first_of_frame <= req.first;
        i_run_length     <= req.run;
        i_pixel_x        <= req.px;
        i_pixel_y        <= req.py;
        i_pixel_value    <= req.pv;
        i_read_address   <= req.raddr;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = fb_predict(req);
        fb_expected.push_back(typed ? lit : predicted);
        fb_sent++;
    endtask

    function automatic void fb_compare(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fb_failed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : score
        t_fb_response want;
        if (i_rst_n && o_done === 1'b1) begin
            if (fb_expected.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0h", $time,
                         {o_read_data, o_next_position, o_current_color, o_frame_full,
                          o_pixels_dropped});
                fb_failed = 1'b1;
            end else begin
                want = fb_expected.pop_front();
                fb_compare("read_data", want.rdata, o_read_data);
                fb_compare("next_position", want.next_pos, o_next_position);
                fb_compare("current_color", want.colour, o_current_color);
                fb_compare("frame_full", want.full, o_frame_full);
                fb_compare("pixels_dropped", want.dropped, o_pixels_dropped);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            idle_count <= 0;
        end else if (idle_count == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin : stimulus
        t_fb_request req;
        int unsigned target;
        foreach (fb_bytes[a]) fb_bytes[a] = '0;
        fb_pos     = 0;
        fb_colour  = 1'b0;
        fb_sent    = 0;
        no_idle    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (FB_ROWS[r]) begin
            repeat (FB_ROWS[r].reps) fb_issue(FB_ROWS[r].req, FB_ROWS[r].typed, FB_ROWS[r].rsp);
        end

        // paint frames, some cut short, with pixel writes, reads and idle commands mixed in
        while (fb_sent < ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            target  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, rpf_pkg::TOTAL_PIXELS)
                                                  : rpf_pkg::TOTAL_PIXELS;
            req       = fb_scramble();
            req.cmd   = rpf_pkg::CMD_RUN;
            req.first = 1'b1;
            fb_issue(req, 1'b0, NO_RSP);
            while (fb_sent < ITEMS && fb_pos < target) begin
                req = fb_scramble();
                if ($urandom_range(0, 9) < 3) begin
                    if (req.cmd == rpf_pkg::CMD_RUN) req.cmd = rpf_pkg::CMD_READ;
                end else begin
                    req.cmd   = rpf_pkg::CMD_RUN;
                    req.first = 1'b0;
                    case ($urandom_range(0, 9))
                        0:       req.run = '0;
                        1, 2:    req.run = rpf_pkg::RUN_W'($urandom_range(1, 8));
                        default: ;
                    endcase
                end
                fb_issue(req, 1'b0, NO_RSP);
            end
            repeat ($urandom_range(0, 3)) begin
                req       = fb_scramble();
                req.cmd   = rpf_pkg::CMD_RUN;
                req.first = 1'b0;
                fb_issue(req, 1'b0, NO_RSP);
            end
        end

        start <= 1'b0;
        while (fb_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!fb_failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
